@@ rtl/core/tvp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared constants and helpers for the trapezoidal velocity profile block.
// ----------------------------------------------------------------------------
package tvp_pkg;

  localparam int TIME_FRAC_BITS_DEF = 16;
  localparam int TIME_W             = 32;
  localparam int REG_W              = 31;
  localparam int VAL_W              = 32;
  localparam int ACC_W              = 66;

  localparam logic [REG_W-1:0] MAX_VELOCITY_RST     = 31'd1174405;
  localparam logic [REG_W-1:0] MAX_ACCELERATION_RST = 31'd167772;
  localparam logic [REG_W-1:0] PATH_LENGTH_RST      = 31'd2108287;

  localparam logic [1:0] REG_MAX_VELOCITY     = 2'd0;
  localparam logic [1:0] REG_MAX_ACCELERATION = 2'd1;
  localparam logic [1:0] REG_PATH_LENGTH      = 2'd2;

  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7FFF_FFFF);
    lo = -ACC_W'(64'sh8000_0000);
    if (v > hi) return 32'h7FFF_FFFF;
    else if (v < lo) return 32'h8000_0000;
    else return v[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/core/tvp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvp_div
// Bit-serial restoring divider, one quotient bit per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
module tvp_div
  import tvp_pkg::*;
#(
  parameter int NUM_W = 47
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [REG_W-1:0]    den,
  output logic                done,
  output logic [TIME_W-1:0]   quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [NUM_W-1:0] q;
  logic [REG_W-1:0] rem;
  logic [REG_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [REG_W:0]   trial;
  logic             ge;

  // remainder stays below the divisor, so it fits in REG_W bits
  always_comb begin
    trial = {rem, num_sh[NUM_W-1]};
    ge    = trial >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      d      <= den;
      rem    <= '0;
      q      <= '0;
    end else if (run) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem    <= ge ? REG_W'(trial - {1'b0, d}) : trial[REG_W-1:0];
      q      <= {q[NUM_W-2:0], ge};
    end
  end

  // zero divisor and oversized quotient both give the saturated time
  assign quot = (d == '0 || |q[NUM_W-1:TIME_W]) ? '1 : q[TIME_W-1:0];

endmodule

@@ rtl/core/trapezoidal_velocity_profile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoidal_velocity_profile
// Trapezoidal speed law setpoint generator: position, velocity, acceleration,
// total move time and phase for each time sample.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          word
//  ------   ---------  -----------------  ---------------------------------
//  in       sink       in_valid/in_stall  time_now
//  out      source     out_valid/out_stall position, velocity, acceleration,
//                                         total_time, phase
//  cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
//  One word per cycle while neither stalled nor busy, through a four-stage pipeline.
//  Ramp time, total time and end position depend only on the registers and
//  are computed after reset and after every register write: two divides on a
//  bit-serial divider, then a multiply for the end position, during which
//  in_stall is high. Stalls at the output back up stage by stage; empty
//  stages still advance, so bubbles are squeezed out.
//
module trapezoidal_velocity_profile
  import tvp_pkg::*;
#(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] time_now,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAL_W-1:0]  position,
  output logic [VAL_W-1:0]  velocity,
  output logic [VAL_W-1:0]  acceleration,
  output logic [TIME_W-1:0] total_time,
  output logic [1:0]        phase,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [VAL_W-1:0]  cfg_data
);

  localparam int NUM_W = REG_W + TIME_FRAC_BITS;
  localparam int SQ_SH = 2 * TIME_FRAC_BITS + 1;
  localparam int RED_W = 63 - TIME_FRAC_BITS;   // product >> TIME_FRAC_BITS
  localparam int FUL_W = 95;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_TS    = 3'd2;
  localparam logic [2:0] S_TF    = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  // registers
  logic [REG_W-1:0] vmax;
  logic [REG_W-1:0] amax;
  logic [REG_W-1:0] plen;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vmax <= MAX_VELOCITY_RST;
      amax <= MAX_ACCELERATION_RST;
      plen <= PATH_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_VELOCITY:     vmax <= cfg_data[REG_W-1:0];
        REG_MAX_ACCELERATION: amax <= cfg_data[REG_W-1:0];
        REG_PATH_LENGTH:      plen <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- profile constants: Ts, Tf, Tf-Ts, end position --------
  logic [2:0]        state;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [REG_W-1:0]  div_den;
  logic              div_done;
  logic [TIME_W-1:0] div_q;
  logic [TIME_W-1:0] ts;
  logic [TIME_W-1:0] tf;
  logic [TIME_W-1:0] tmts;
  logic [RED_W-1:0]  pfin;
  logic [TIME_W:0]   tf_sum;
  logic [62:0]       fin_prod;
  logic              busy;

  assign busy      = state != S_IDLE;
  assign div_start = (state == S_START) || (state == S_TS && div_done);
  assign div_num   = (state == S_START) ? {vmax, TIME_FRAC_BITS'(0)}
                                        : {plen, TIME_FRAC_BITS'(0)};
  assign div_den   = (state == S_START) ? amax : vmax;
  assign tf_sum    = {1'b0, div_q} + {1'b0, ts};
  assign fin_prod  = 63'(vmax) * 63'(tmts);

  tvp_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_START;
    end else if (cfg_valid && cfg_ready) begin
      state <= S_START;
    end else begin
      unique case (state)
        S_START: state <= S_TS;
        S_TS:    if (div_done) state <= S_TF;
        S_TF:    if (div_done) state <= S_FIN;
        S_FIN:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_TS && div_done) ts <= div_q;
    if (state == S_TF && div_done) begin
      tf   <= tf_sum[TIME_W] ? '1 : tf_sum[TIME_W-1:0];
      tmts <= (tf_sum[TIME_W] ? '1 : tf_sum[TIME_W-1:0]) - ts;
    end
    if (state == S_FIN) pfin <= fin_prod[62:TIME_FRAC_BITS];
  end

  // ---------------- pipeline control --------------------------------------
  logic v1, v2, v3;
  logic en1, en2, en3, en4;
  logic in_acc;

  assign en4      = !out_valid || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = busy || !en1;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_acc;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  // ---------------- stage 1: phase decision, operand select ---------------
  logic [1:0]        ph0;
  logic [1:0]        ph1, ph2, ph3;
  logic [TIME_W-1:0] x1, x2;
  logic [TIME_W:0]   y1;

  always_comb begin
    priority if (time_now <= ts) ph0 = PH_ACCEL;
    else if (time_now <= tmts)   ph0 = PH_CRUISE;
    else if (time_now <= tf)     ph0 = PH_DECEL;
    else                         ph0 = PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (en1 && in_acc) begin
      ph1 <= ph0;
      x1  <= (ph0 == PH_ACCEL) ? time_now : tf - time_now;
      y1  <= {time_now, 1'b0} - {1'b0, ts};   // 2t - Ts, cruise only
    end
  end

  // ---------------- stage 2: rate products --------------------------------
  logic [62:0] p1;
  logic [63:0] c2;

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      ph2 <= ph1;
      x2  <= x1;
      p1  <= 63'(amax) * 63'(x1);
      c2  <= 64'(vmax) * 64'(y1);
    end
  end

  // ---------------- stage 3: square partial products, velocity, cruise position ---
  logic [63:0]       plo;
  logic [62:0]       phi;
  logic [RED_W-1:0]  vel3;
  logic [RED_W-1:0]  posc3;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      ph3   <= ph2;
      plo   <= 64'(p1[31:0]) * 64'(x2);
      phi   <= 63'(p1[62:32]) * 63'(x2);
      vel3  <= p1[62:TIME_FRAC_BITS];
      posc3 <= RED_W'(c2 >> (TIME_FRAC_BITS + 1));
    end
  end

  // ---------------- stage 4: combine, saturate, output register -----------
  logic [FUL_W-1:0]         full;
  logic [FUL_W-1:0]         sq_sh;
  logic [48:0]              sq;
  logic signed [ACC_W-1:0]  pos_w;
  logic [VAL_W-1:0]         vel_sat;
  logic [VAL_W-1:0]         pos_n, vel_n, acc_n;

  always_comb begin
    full  = {phi, 32'd0} + FUL_W'(plo);
    sq_sh = full >> SQ_SH;
    // capped at 2^48
    sq    = (sq_sh > (FUL_W'(1) << 48)) ? {1'b1, 48'd0} : sq_sh[48:0];
    vel_sat = (|vel3[RED_W-1:VAL_W-1]) ? 32'h7FFF_FFFF : {1'b0, vel3[VAL_W-2:0]};
    unique case (ph3)
      PH_ACCEL: begin
        pos_w = $signed(ACC_W'(sq));
        vel_n = vel_sat;
        acc_n = {1'b0, amax};
      end
      PH_CRUISE: begin
        pos_w = $signed(ACC_W'(posc3));
        vel_n = {1'b0, vmax};
        acc_n = '0;
      end
      PH_DECEL: begin
        pos_w = $signed(ACC_W'(pfin)) - $signed(ACC_W'(sq));
        vel_n = vel_sat;
        acc_n = -{1'b0, amax};
      end
      default: begin
        pos_w = $signed(ACC_W'(pfin));
        vel_n = '0;
        acc_n = '0;
      end
    endcase
    pos_n = sat32(pos_w);
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      position     <= pos_n;
      velocity     <= vel_n;
      acceleration <= acc_n;
      total_time   <= tf;
      phase        <= ph3;
    end
  end

  // ---------------- assertions --------------------------------------------
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("input taken while profile constants pending");

  a_done_rest: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == PH_DONE |-> velocity == '0 && acceleration == '0)
    else $error("nonzero rate after end of move");

  a_decel_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == PH_DECEL || phase == PH_ACCEL) |-> !velocity[VAL_W-1])
    else $error("negative speed on a ramp");

endmodule

@@ dv/tvp_profile_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvp_profile_checker
// Watches the cfg, in and out channels of the profile generator. It keeps its
// own copy of the three registers, predicts each output word from each
// accepted time sample and compares it in order with what comes out.
// ----------------------------------------------------------------------------
module tvp_profile_checker
  import tvp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [TIME_W-1:0] time_now,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [VAL_W-1:0]  position,
  input  logic [VAL_W-1:0]  velocity,
  input  logic [VAL_W-1:0]  acceleration,
  input  logic [TIME_W-1:0] total_time,
  input  logic [1:0]        phase,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [VAL_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending,
  output int                words_checked
);

  localparam int TF = TIME_FRAC_BITS_DEF;
  localparam logic [127:0] TIME_MAX = 128'hFFFF_FFFF;
  localparam logic [127:0] POS_CAP  = 128'd1 << 48;

  typedef struct packed {
    logic [VAL_W-1:0]  position;
    logic [VAL_W-1:0]  velocity;
    logic [VAL_W-1:0]  acceleration;
    logic [TIME_W-1:0] total_time;
    logic [1:0]        phase;
  } profile_t;

  logic [REG_W-1:0] vmax_q;
  logic [REG_W-1:0] amax_q;
  logic [REG_W-1:0] length_q;
  profile_t         profile_q[$];

  // saturating time quotient; zero divisor gives the saturated time
  function automatic logic [127:0] time_quotient(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    if (den == 0) return TIME_MAX;
    q = num / den;
    return (q > TIME_MAX) ? TIME_MAX : q;
  endfunction

  // a*b*b / 2^(2TF+1), capped
  function automatic logic [127:0] ramp_distance(logic [127:0] a, logic [127:0] b);
    logic [127:0] r;
    r = (a * b * b) >> (2 * TF + 1);
    return (r > POS_CAP) ? POS_CAP : r;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -128'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic profile_t predict_profile(logic [TIME_W-1:0] t_in);
    logic [127:0] t, vm, am, ts, tf, d;
    logic signed [127:0] pos, vel, acc;
    profile_t p;
    t  = t_in;
    vm = vmax_q;
    am = amax_q;
    ts = time_quotient(vm << TF, am);
    tf = time_quotient(128'(length_q) << TF, vm) + ts;
    if (tf > TIME_MAX) tf = TIME_MAX;
    if (t <= ts) begin
      pos = ramp_distance(am, t);
      vel = (am * t) >> TF;
      acc = am;
      p.phase = PH_ACCEL;
    end else if (t <= tf - ts) begin
      pos = (vm * (2 * t - ts)) >> (TF + 1);
      vel = vm;
      acc = 0;
      p.phase = PH_CRUISE;
    end else if (t <= tf) begin
      d   = tf - t;
      pos = $signed((vm * (tf - ts)) >> TF) - $signed(ramp_distance(am, d));
      vel = (am * d) >> TF;
      acc = -$signed(am);
      p.phase = PH_DECEL;
    end else begin
      pos = (vm * (tf - ts)) >> TF;
      vel = 0;
      acc = 0;
      p.phase = PH_DONE;
    end
    p.position     = clamp32(pos);
    p.velocity     = clamp32(vel);
    p.acceleration = clamp32(acc);
    p.total_time   = tf[31:0];
    return p;
  endfunction

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $error("%s mismatch: expected %h, got %h", field, want, got);
    fail_count++;
  endtask

  assign pending = profile_q.size();

  initial begin
    fail_count    = 0;
    words_checked = 0;
  end

  always @(posedge clk) begin
    profile_t want;
    if (rst) begin
      vmax_q   <= MAX_VELOCITY_RST;
      amax_q   <= MAX_ACCELERATION_RST;
      length_q <= PATH_LENGTH_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_VELOCITY:     vmax_q   <= cfg_data[REG_W-1:0];
          REG_MAX_ACCELERATION: amax_q   <= cfg_data[REG_W-1:0];
          REG_PATH_LENGTH:      length_q <= cfg_data[REG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        profile_q.push_back(predict_profile(time_now));
      if (out_valid && !out_stall) begin
        if (profile_q.size() == 0) begin
          $error("output word with nothing expected");
          fail_count++;
        end else begin
          want = profile_q.pop_front();
          words_checked++;
          if (position !== want.position) report("position", want.position, position);
          if (velocity !== want.velocity) report("velocity", want.velocity, velocity);
          if (acceleration !== want.acceleration)
            report("acceleration", want.acceleration, acceleration);
          if (total_time !== want.total_time)
            report("total_time", want.total_time, total_time);
          if (phase !== want.phase) report("phase", want.phase, phase);
        end
      end
    end
  end

endmodule

@@ dv/tb_trapezoidal_velocity_profile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trapezoidal_velocity_profile
// Drives time samples through the profile generator under a series of
// register settings (reset values, extremes, zero divisors, short paths,
// random) with bursty input and random output stalls; the checker beside the
// block predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_trapezoidal_velocity_profile;
  import tvp_pkg::*;

  localparam int TF = TIME_FRAC_BITS_DEF;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TIME_W-1:0] time_now = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VAL_W-1:0]  position, velocity, acceleration;
  logic [TIME_W-1:0] total_time;
  logic [1:0]        phase;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = REG_MAX_VELOCITY;
  logic [VAL_W-1:0]  cfg_data = '0;
  int                fail_count, pending, words_checked;

  // our own view of the registers, only used to aim time samples at phases
  logic [REG_W-1:0]  vmax_set = MAX_VELOCITY_RST;
  logic [REG_W-1:0]  amax_set = MAX_ACCELERATION_RST;
  logic [REG_W-1:0]  length_set = PATH_LENGTH_RST;
  logic [63:0]       ramp_t, end_t;
  int                samples_sent = 0;
  int                settings_run = 0;
  int                stall_mode = 0;
  bit                stim_done = 1'b0;

  always #6 clk = ~clk;

  trapezoidal_velocity_profile i_dut (.*);

  tvp_profile_checker i_checker (.*);

  // Receiver stall: the mode changes at random - none, light
  // random, heavy random or long solid stalls. Released once stimulus ends.
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    if (stim_done) out_stall = 1'b0;
    else case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 3) == 0);
      2: out_stall = ($urandom_range(0, 3) != 0);
      default: out_stall = ($urandom_range(0, 15) != 0);
    endcase
  end

  // ramp and end times as the block sees them, zero divisors saturate
  task automatic update_times();
    logic [63:0] q;
    ramp_t = (amax_set == 0) ? 64'hFFFF_FFFF : (64'(vmax_set) << TF) / amax_set;
    if (ramp_t > 64'hFFFF_FFFF) ramp_t = 64'hFFFF_FFFF;
    q = (vmax_set == 0) ? 64'hFFFF_FFFF : (64'(length_set) << TF) / vmax_set;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    end_t = q + ramp_t;
    if (end_t > 64'hFFFF_FFFF) end_t = 64'hFFFF_FFFF;
  endtask

  // register write; only done with the pipe drained
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      REG_MAX_VELOCITY:     vmax_set   = data[REG_W-1:0];
      REG_MAX_ACCELERATION: amax_set   = data[REG_W-1:0];
      default:              length_set = data[REG_W-1:0];
    endcase
  endtask

  // one time sample; valid stays high into the next word of a burst
  task automatic send_sample(logic [31:0] t);
    in_valid = 1'b1;
    time_now = t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic idle_gap(int cycles);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // sample aimed at a phase edge, inside a phase, or anywhere
  function automatic logic [31:0] pick_time();
    logic [63:0] span;
    logic [63:0] edges[6];
    edges = '{0, ramp_t, ramp_t + 1, end_t - ramp_t, end_t, end_t + 1};
    span = end_t + (end_t >> 2) + 1;
    case ($urandom_range(0, 9))
      0, 1:    return 32'(edges[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1);
      2:       return $urandom();
      default: return 32'(({$urandom(), $urandom()}) % span);
    endcase
  endfunction

  // random burst traffic: bursts of 1..24 words, with idle gaps between some bursts
  task automatic run_traffic(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && count > 0) begin
        send_sample(pick_time());
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
    end
    in_valid = 1'b0;
  endtask

  // drain the pipe, let it settle, then apply one setting
  task automatic new_setting(logic [31:0] vm, logic [31:0] am, logic [31:0] len);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
    write_reg(REG_MAX_VELOCITY, vm);
    write_reg(REG_MAX_ACCELERATION, am);
    write_reg(REG_PATH_LENGTH, len);
    update_times();
    settings_run++;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    update_times();

    // directed: reset settings, every phase edge and field extreme
    send_sample(32'd0);
    send_sample(32'd1);
    send_sample(32'(ramp_t));
    send_sample(32'(ramp_t + 1));
    send_sample(32'(end_t - ramp_t));
    send_sample(32'(end_t - ramp_t + 1));
    send_sample(32'(end_t));
    send_sample(32'(end_t + 1));
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hAAAA_AAAA);
    send_sample(32'h5555_5555);
    run_traffic(120);

    // extremes: smallest values with an empty path
    new_setting(32'd1, 32'd1, 32'd0);
    run_traffic(40);
    // largest of everything; bit 31 of the data must be dropped
    new_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_traffic(50);
    // very long ramp: time saturates
    new_setting(32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF);
    run_traffic(40);
    // tiny speed, strong acceleration: long cruise
    new_setting(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_traffic(40);
    // zero acceleration: stuck in the ramp phase
    new_setting(32'd1174405, 32'd0, 32'd2108287);
    run_traffic(40);
    // zero speed: total time saturates
    new_setting(32'd0, 32'd167772, 32'd2108287);
    run_traffic(40);
    // short path: ramp up straight into ramp down
    new_setting(32'd16777216, 32'd16777216, 32'd4194304);
    run_traffic(60);

    // random settings, mostly in a realistic range
    repeat (8) begin
      if ($urandom_range(0, 3) == 0)
        new_setting($urandom(), $urandom(), $urandom());
      else
        new_setting($urandom_range(1, 1 << 26), $urandom_range(1, 1 << 26),
                    $urandom_range(0, 1 << 28));
      run_traffic(55);
    end

    // back to reset values
    new_setting(MAX_VELOCITY_RST, MAX_ACCELERATION_RST, PATH_LENGTH_RST);
    run_traffic(40);

    stim_done = 1'b1;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("Ran %0d time samples over %0d register settings, %0d words checked.",
             samples_sent, settings_run + 1, words_checked);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // generous watchdog
  initial begin
    #3_000_000;
    $display("Timeout with %0d words outstanding.", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
